// ===== design/pnca_pkg.sv =====
// ----------------------------------------------------------------------------
// pnca_pkg
// Shared types, constants and saturating add of the penalized nearest-center assignment block.
// ----------------------------------------------------------------------------
package pnca_pkg;

	localparam int MAX_CLUSTERS = 16;
	localparam int MAX_DIMS     = 16;
	localparam int MAX_POINTS   = 1024;

	localparam int CW = $clog2(MAX_CLUSTERS);
	localparam int DW = $clog2(MAX_DIMS);
	localparam int PW = $clog2(MAX_POINTS);

	typedef enum logic [1:0] {
		ACT_CENTER = 2'd0,
		ACT_LABEL  = 2'd1,
		ACT_COORD  = 2'd2,
		ACT_LINK   = 2'd3
	} action_t;

	localparam logic REG_CLUSTERS = 1'b0;
	localparam logic REG_DIMS     = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LABEL,
		ST_ACC,
		ST_SCAN,
		ST_OUT
	} state_t;

	function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
		logic [64:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[64] ? '1 : s[63:0];
	endfunction

endpackage

// ===== design/pnca_label_ram.sv =====
// ----------------------------------------------------------------------------
// pnca_label_ram
// Point label memory, one write and one registered read port.
// ----------------------------------------------------------------------------
module pnca_label_ram
	import pnca_pkg::*;
(
	input  logic          clk,
	input  logic          we,
	input  logic [PW-1:0] waddr,
	input  logic [CW-1:0] wdata,
	input  logic [PW-1:0] raddr,
	output logic [CW-1:0] rdata
);

	logic [CW-1:0] mem [MAX_POINTS];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== design/pnca_center_ram.sv =====
// ----------------------------------------------------------------------------
// pnca_center_ram
// Center coordinate memory, indexed by {cluster, dimension}.
// ----------------------------------------------------------------------------
module pnca_center_ram
	import pnca_pkg::*;
(
	input  logic             clk,
	input  logic             we,
	input  logic [CW+DW-1:0] waddr,
	input  logic [31:0]      wdata,
	input  logic [CW+DW-1:0] raddr,
	output logic [31:0]      rdata
);

	logic [31:0] mem [MAX_CLUSTERS*MAX_DIMS];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== design/penalized_nearest_center_assign_top.sv =====
// ----------------------------------------------------------------------------
// penalized_nearest_center_assign_top
// Streams point coordinates and constraint links, charges every cluster's
// cost, then picks the cheapest cluster and stores it as the point's label.
// ----------------------------------------------------------------------------
//  channel | handshake           | payload
//  in      | in_valid / in_stall | action .. last_of_point
//  out     | out_valid/ out_stall| assigned_point, chosen_cluster, chosen_cost
//  cfg     | cfg_we              | cfg_index, cfg_data
//
//  Steps per accepted item (K = clusters in use): center and label loads
//  are taken in the idle state. A coordinate on a position in use issues
//  one center read per cluster, then the read and the squared-distance
//  stage drain before the accumulators settle; a coordinate on a position
//  not in use issues no reads. A link reads the neighbor's label, then
//  updates one accumulator per cycle. A last item adds an argmin scan over
//  the K accumulators and a state that posts the result.
//  After reset all 1024 label store entries are cleared, one per cycle,
//  with input stalled. Accumulators are 16 registers with valid bits cleared
//  by reset and after each result.
//  A waiting result holds the block; input is stalled until it is taken.
// ----------------------------------------------------------------------------
module penalized_nearest_center_assign_top
	import pnca_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  action,
	input  logic [3:0]  cluster_index,
	input  logic [3:0]  dimension_index,
	input  logic signed [31:0] coordinate,
	input  logic [9:0]  point_index,
	input  logic [9:0]  neighbor_index,
	input  logic [47:0] link_weight,
	input  logic        link_is_cannot,
	input  logic        last_of_point,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [9:0]  assigned_point,
	output logic [3:0]  chosen_cluster,
	output logic [63:0] chosen_cost,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [4:0]  cfg_data
);

	state_t state_q, state_d;

	logic [4:0] clusters_q, dims_q;
	logic [CW-1:0] k_last;          // highest cluster in use
	logic [DW:0]   dims_use;

	// request latched at acceptance
	action_t       act_q;
	logic [DW-1:0] didx_q;
	logic [31:0]   coord_q;
	logic [PW-1:0] pidx_q, nidx_q;
	logic [47:0]   weight_q;
	logic          cannot_q, last_q, active_q;

	logic [CW-1:0] cnt_q;           // cluster walked by the sequencer
	logic          rd_s1;           // center read issued last cycle
	logic [CW-1:0] c_s1;
	logic          sq_s2;
	logic [CW-1:0] c_s2;
	logic [63:0]   sq_s2_val;
	logic [CW-1:0] lab_q;

	logic [63:0]   acc_q [MAX_CLUSTERS];
	logic [MAX_CLUSTERS-1:0] acc_vld_q;

	// label store clearing pass after reset
	logic          clr_q;
	logic [PW-1:0] clr_addr_q;

	logic [63:0]   bcost_q;
	logic [CW-1:0] bidx_q;
	logic          out_valid_q;
	logic [PW-1:0] opt_q;

	logic          accept;
	logic [31:0]   ctr_rd;
	logic [CW-1:0] lab_rd;
	logic          lab_we;
	logic [PW-1:0] lab_waddr;
	logic [CW-1:0] lab_wdata;
	logic          ctr_we;
	logic [CW-1:0] k_clamp;

	always_comb begin
		if (clusters_q == 5'd0) begin
			k_clamp = '0;
		end else if (clusters_q > 5'(MAX_CLUSTERS)) begin
			k_clamp = CW'(MAX_CLUSTERS - 1);
		end else begin
			k_clamp = CW'(clusters_q - 5'd1);
		end
		dims_use = (dims_q > 5'(MAX_DIMS)) ? (DW+1)'(MAX_DIMS) : dims_q[DW:0];
	end
	assign k_last = k_clamp;

	assign in_stall = (state_q != ST_IDLE) || out_valid_q || clr_q;
	assign accept   = in_valid && !in_stall;

	// center memory: written on center loads, read one cluster per cycle
	assign ctr_we = accept && (action_t'(action) == ACT_CENTER);
	pnca_center_ram u_ctr (
		.clk   (clk),
		.we    (ctr_we),
		.waddr ({cluster_index, dimension_index}),
		.wdata (coordinate),
		.raddr ({cnt_q, didx_q}),
		.rdata (ctr_rd)
	);

	// label memory: clearing, loads, assignment write-back, neighbor reads
	always_comb begin
		lab_we    = 1'b0;
		lab_waddr = point_index;
		lab_wdata = cluster_index;
		if (clr_q) begin
			lab_we    = 1'b1;
			lab_waddr = clr_addr_q;
			lab_wdata = '0;
		end else if (accept && action_t'(action) == ACT_LABEL) begin
			lab_we = 1'b1;
		end else if (state_q == ST_OUT) begin
			lab_we    = 1'b1;
			lab_waddr = pidx_q;
			lab_wdata = bidx_q;
		end
	end

	pnca_label_ram u_lab (
		.clk   (clk),
		.we    (lab_we),
		.waddr (lab_waddr),
		.wdata (lab_wdata),
		.raddr (neighbor_index),
		.rdata (lab_rd)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					unique case (action_t'(action))
						ACT_CENTER, ACT_LABEL: state_d = ST_IDLE;
						ACT_COORD: state_d = ST_ACC;
						ACT_LINK:  state_d = ST_LABEL;
						default:   state_d = ST_IDLE;
					endcase
				end
			end
			ST_LABEL: state_d = ST_ACC;
			ST_ACC: begin
				if (act_q == ACT_LINK) begin
					if (cnt_q == k_last) begin
						state_d = last_q ? ST_SCAN : ST_IDLE;
					end
				end else if (!rd_s1 && !sq_s2 && cnt_q == '0 && active_q) begin
					state_d = last_q ? ST_SCAN : ST_IDLE;
				end
			end
			ST_SCAN: begin
				if (cnt_q == k_last) begin
					state_d = ST_OUT;
				end
			end
			ST_OUT:  state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// sequencer, multiply path, accumulators
	logic signed [32:0] diff;
	logic [32:0]        mag;
	logic [CW-1:0]      lab_eff;
	logic               hit;
	logic [63:0]        acc_rd;
	logic [63:0]        scan_rd;

	assign diff = $signed({coord_q[31], coord_q}) - $signed({ctr_rd[31], ctr_rd});
	assign mag  = diff[32] ? 33'(-diff) : diff;
	assign lab_eff = lab_q;
	assign hit = cannot_q ? (cnt_q == lab_eff) : (cnt_q != lab_eff);
	assign acc_rd  = acc_vld_q[c_s2] ? acc_q[c_s2] : 64'd0;
	assign scan_rd = acc_vld_q[cnt_q] ? acc_q[cnt_q] : 64'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			rd_s1       <= 1'b0;
			sq_s2       <= 1'b0;
			active_q    <= 1'b0;
			acc_vld_q   <= '0;
			clr_q       <= 1'b1;
			clr_addr_q  <= '0;
			out_valid_q <= 1'b0;
			clusters_q  <= 5'd2;
			dims_q      <= 5'd2;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_CLUSTERS: clusters_q <= cfg_data;
					REG_DIMS:     dims_q     <= cfg_data;
					default:      ;
				endcase
			end
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (clr_q) begin
				clr_addr_q <= clr_addr_q + 1'b1;
				if (clr_addr_q == PW'(MAX_POINTS - 1)) begin
					clr_q <= 1'b0;
				end
			end
			rd_s1 <= 1'b0;
			sq_s2 <= rd_s1;
			if (state_q == ST_IDLE && accept) begin
				cnt_q    <= '0;
				active_q <= 1'b0;
			end
			if (state_q == ST_ACC) begin
				if (act_q == ACT_COORD) begin
					if (!active_q) begin
						// issue reads for each cluster in use, on positions in use
						if ({1'b0, didx_q} < dims_use) begin
							rd_s1 <= 1'b1;
							if (cnt_q == k_last) begin
								active_q <= 1'b1;
								cnt_q    <= '0;
							end else begin
								cnt_q <= cnt_q + 1'b1;
							end
						end else begin
							active_q <= 1'b1;
							cnt_q    <= '0;
						end
					end
				end else begin
					if (hit) begin
						acc_q[cnt_q]     <= sat_add(scan_rd, {16'd0, weight_q});
						acc_vld_q[cnt_q] <= 1'b1;
					end
					cnt_q <= (cnt_q == k_last) ? '0 : cnt_q + 1'b1;
				end
			end
			if (sq_s2) begin
				acc_q[c_s2]     <= sat_add(acc_rd, sq_s2_val);
				acc_vld_q[c_s2] <= 1'b1;
			end
			if (state_q == ST_SCAN) begin
				cnt_q <= (cnt_q == k_last) ? '0 : cnt_q + 1'b1;
			end
			if (state_q == ST_OUT) begin
				out_valid_q <= 1'b1;
				acc_vld_q   <= '0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			act_q    <= action_t'(action);
			didx_q   <= dimension_index;
			coord_q  <= coordinate;
			pidx_q   <= point_index;
			nidx_q   <= neighbor_index;
			weight_q <= link_weight;
			cannot_q <= link_is_cannot;
			last_q   <= last_of_point;
		end
		if (state_q == ST_LABEL) begin
			lab_q <= lab_rd;
		end
		c_s1      <= cnt_q;
		c_s2      <= c_s1;
		sq_s2_val <= 64'(mag) * 64'(mag);
		if (state_q == ST_SCAN) begin
			if (cnt_q == '0 || scan_rd < bcost_q) begin
				bcost_q <= scan_rd;
				bidx_q  <= cnt_q;
			end
		end
		if (state_q == ST_OUT) begin
			opt_q <= pidx_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign assigned_point = opt_q;
	assign chosen_cluster = bidx_q;
	assign chosen_cost    = bcost_q;

	// a result is never posted while one is still waiting
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT) |-> !out_valid_q)
		else $error("result overwritten");

	// no request is taken while a result waits
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !accept)
		else $error("request accepted under pending result");

	// the scan always follows a last item
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN && state_d == ST_OUT) |-> last_q)
		else $error("scan without last mark");

	// nothing is taken while the label store is being cleared
	assert property (@(posedge clk) disable iff (!arst_n)
		clr_q |-> !accept)
		else $error("request accepted during label clear");

endmodule
